[hw/rtl/centered_moving_average_core_assert.svh]
// Assertion macros shared by the checker of the centered moving average core.
// No dependencies; included by the checker file.
`ifndef CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH
`define CENTERED_MOVING_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define CMA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cma check failed");

// next-cycle implication, disabled while reset is asserted
`define CMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cma check failed");

`endif

[hw/rtl/cma_pkg.sv]
// Shared constants for the centered moving average core.
// No dependencies; used by the core, the divider and the checker.
`timescale 1ns / 1ps

package cma_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int MAX_WINDOW_DEF  = 64;

	// window_size register
	localparam int             CFG_BITS     = 7;
	localparam int             WINDOW_MIN   = 2;
	localparam logic [CFG_BITS-1:0] WINDOW_RESET = 7'd20;

endpackage

[hw/rtl/cma_div.sv]
// Radix-2 restoring divider: signed dividend by unsigned divisor, truncated toward zero.
// One quotient bit per cycle; a zero divisor gives a zero quotient. Uses cma_pkg.
`timescale 1ns / 1ps

module cma_div #(
	parameter int DW = 23,                 // dividend width
	parameter int VW = cma_pkg::CFG_BITS,  // divisor width
	parameter int QW = cma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] dividend,
	input  logic        [VW-1:0] divisor,
	output logic                 done,
	output logic signed [QW-1:0] quotient
);

	localparam int CNTW = $clog2(DW + 1);

	logic            run_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   num_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   den_q;
	logic            neg_q;
	logic            zero_q;

	logic [DW-1:0] mag;
	logic [VW:0]   shifted;
	logic          ge;
	logic [VW:0]   diff;
	logic [DW-1:0] signed_q;

	assign mag     = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;
	assign shifted = {rem_q, num_q[DW-1]};
	assign ge      = shifted >= {1'b0, den_q};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNTW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out at the top, quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= mag;
			rem_q  <= '0;
			den_q  <= divisor;
			neg_q  <= dividend[DW-1];
			zero_q <= (divisor == '0);
		end else if (run_q) begin
			rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
			num_q <= {num_q[DW-2:0], ge};
		end
	end

	assign signed_q = neg_q ? (~num_q + DW'(1)) : num_q;
	assign quotient = zero_q ? '0 : signed_q[QW-1:0];
	assign done     = done_q;

endmodule

[hw/rtl/centered_moving_average_core.sv]
// Centered moving average core: ring of recent samples in a synchronous RAM,
// running sum, sequencer for the tail flush. Uses cma_pkg and cma_div.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------
//   input    | in_valid / in_ready      | sample, last
//   output   | out_valid / out_ready    | mean, last_res, short_stream
//   config   | cfg_wr_en (no wait)      | cfg_wr_data (window_size)
//
// One item at a time. An item that gives a mean waits for the one-bit-per-cycle
// divider; an item without a result and a short-stream item skip it. The last
// item adds W/2+1 tail means, each computed by the divider.
// The RAM is read into a register at the write pointer; no clearing pass after reset.
// A stalled output holds the sequencer in its push state; the input stays closed.
`timescale 1ns / 1ps

module centered_moving_average_core #(
	parameter int MAX_WINDOW  = cma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] mean,
	output logic                          last_res,
	output logic                          short_stream,
	input  logic                          cfg_wr_en,
	input  logic [cma_pkg::CFG_BITS-1:0]  cfg_wr_data
);

	localparam int CW       = cma_pkg::CFG_BITS;
	localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int IW       = (AW > CW) ? AW : CW;
	localparam int SUM_BITS = SAMPLE_BITS + AW + 1;
	localparam int WCAP     = (MAX_WINDOW < (2**CW - 1)) ? MAX_WINDOW : (2**CW - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_PUSH,
		ST_TREAD,
		ST_TSUB
	} state_t;

	state_t state_q;

	logic [CW-1:0]                window_q;
	logic signed [SUM_BITS-1:0]   sum_q;
	logic [CW-1:0]                seen_q;
	logic [AW-1:0]                wp_q;
	logic [CW-1:0]                k_q;
	logic                         tail_q;
	logic                         last_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                         res_last_q;
	logic                         res_short_q;
	logic                         out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_q;
	logic                         last_res_q;
	logic                         short_q;

	logic [SAMPLE_BITS-1:0]        delay_line [MAX_WINDOW];
	logic signed [SAMPLE_BITS-1:0] rd_data_q;

	logic [CW-1:0]               w_eff;
	logic [CW-1:0]               half;
	logic                        full;
	logic [CW-1:0]               seen_inc;
	logic                        upd_short;
	logic                        upd_div;
	logic [IW-1:0]               wp_plus;
	logic [AW-1:0]               wp_next;
	logic signed [SUM_BITS-1:0]  delta;
	logic signed [SUM_BITS-1:0]  sum_next;
	logic                        div_start;
	logic [CW-1:0]               div_divisor;
	logic                        div_done;
	logic signed [SAMPLE_BITS-1:0] div_quot;
	logic                        mem_we;
	logic                        push_ok;

	always_comb begin
		if (window_q < CW'(cma_pkg::WINDOW_MIN)) begin
			w_eff = CW'(cma_pkg::WINDOW_MIN);
		end else if (window_q > CW'(WCAP)) begin
			w_eff = CW'(WCAP);
		end else begin
			w_eff = window_q;
		end
	end

	assign half     = w_eff >> 1;
	assign full     = (seen_q == w_eff);
	assign seen_inc = seen_q + CW'(1);
	assign upd_short = !full && last_q && (seen_inc < w_eff);
	assign upd_div   = full || (seen_q > half);

	assign wp_plus = IW'(wp_q) + IW'(1);
	assign wp_next = (wp_plus == IW'(w_eff)) ? '0 : AW'(wp_plus);

	// rd_data_q holds the slot at the write pointer: the oldest sample once full
	always_comb begin
		if (state_q == ST_TSUB) begin
			delta = -SUM_BITS'(rd_data_q);
		end else if (full) begin
			delta = SUM_BITS'(sample_q) - SUM_BITS'(rd_data_q);
		end else begin
			delta = SUM_BITS'(sample_q);
		end
	end

	assign sum_next = sum_q + delta;

	always_comb begin
		if (state_q == ST_TSUB) begin
			div_divisor = w_eff - CW'(1) - k_q;
		end else if (full) begin
			div_divisor = w_eff;
		end else begin
			div_divisor = seen_inc;
		end
	end

	assign div_start = ((state_q == ST_UPD) && !upd_short && upd_div) || (state_q == ST_TSUB);
	assign mem_we    = (state_q == ST_UPD);
	assign push_ok   = !out_valid_q || out_ready;

	cma_div #(
		.DW(SUM_BITS),
		.VW(CW),
		.QW(SAMPLE_BITS)
	) u_cma_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_next),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// sample ring; writes happen only in ST_UPD and every read is sampled only after
	// the pointer settles, so no same-entry forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			delay_line[wp_q] <= sample_q;
		end
		rd_data_q <= delay_line[wp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= cma_pkg::WINDOW_RESET;
			sum_q       <= '0;
			seen_q      <= '0;
			wp_q        <= '0;
			k_q         <= '0;
			tail_q      <= 1'b0;
			last_q      <= 1'b0;
			sample_q    <= '0;
			res_last_q  <= 1'b0;
			res_short_q <= 1'b0;
			out_valid_q <= 1'b0;
			mean_q      <= '0;
			last_res_q  <= 1'b0;
			short_q     <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sample_q <= sample;
						last_q   <= last;
						state_q  <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_short) begin
						res_short_q <= 1'b1;
						res_last_q  <= 1'b1;
						sum_q       <= '0;
						seen_q      <= '0;
						wp_q        <= '0;
						state_q     <= ST_PUSH;
					end else begin
						sum_q  <= sum_next;
						seen_q <= full ? seen_q : seen_inc;
						wp_q   <= wp_next;
						if (upd_div) begin
							res_short_q <= 1'b0;
							res_last_q  <= 1'b0;
							state_q     <= ST_DIV;
						end else if (last_q) begin
							// window of two just filled: no mean, straight to the tail
							tail_q  <= 1'b1;
							k_q     <= '0;
							state_q <= ST_TREAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ok) begin
						out_valid_q <= 1'b1;
						mean_q      <= res_short_q ? '0 : div_quot;
						last_res_q  <= res_last_q;
						short_q     <= res_short_q;
						if (res_short_q) begin
							res_short_q <= 1'b0;
							state_q     <= ST_IDLE;
						end else if (tail_q) begin
							if (res_last_q) begin
								tail_q  <= 1'b0;
								sum_q   <= '0;
								seen_q  <= '0;
								wp_q    <= '0;
								state_q <= ST_IDLE;
							end else begin
								k_q     <= k_q + CW'(1);
								state_q <= ST_TREAD;
							end
						end else if (last_q) begin
							tail_q  <= 1'b1;
							k_q     <= '0;
							state_q <= ST_TREAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_TREAD: begin
					state_q <= ST_TSUB;
				end
				ST_TSUB: begin
					sum_q       <= sum_next;
					wp_q        <= wp_next;
					res_last_q  <= (k_q == half);
					res_short_q <= 1'b0;
					state_q     <= ST_DIV;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// register write restarts the stream
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
				sum_q    <= '0;
				seen_q   <= '0;
				wp_q     <= '0;
			end
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign mean         = mean_q;
	assign last_res     = last_res_q;
	assign short_stream = short_q;

endmodule

[hw/rtl/cma_checker.sv]
// Port-level checks for the centered moving average core, attached by bind.
// Depends on cma_pkg and centered_moving_average_core_assert.svh.
`timescale 1ns / 1ps
`include "centered_moving_average_core_assert.svh"

module cma_checker #(
	parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] mean,
	input logic                          last_res,
	input logic                          short_stream
);

	// a stalled result holds
	`CMA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mean) && $stable(last_res) && $stable(short_stream))

	// the short-stream result is the stream's final result, with zero mean
	`CMA_ASSERT_NOW(a_short_final, clk, arst_n, out_valid && short_stream, last_res && (mean == '0))

	// one transaction in flight: input closes right after an accept
	`CMA_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind centered_moving_average_core cma_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cma_checker (.*);
